/* rtl/core/debounced_updown_counter_blinker_macros.svh */
// Assertion shorthands shared by the top module and ducb_period.
// Each one samples on clk and is disabled while rst_n is low.
`ifndef DEBOUNCED_UPDOWN_COUNTER_BLINKER_MACROS_SVH
`define DEBOUNCED_UPDOWN_COUNTER_BLINKER_MACROS_SVH

// Condition holds at every clock edge.
`define DUCB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DUCB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DUCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ducb_pkg.sv */
package ducb_pkg;

  localparam int CFG_W    = 20;
  localparam int CNT_W    = 7;
  localparam int DT_W     = 16;
  localparam int PERIOD_W = CFG_W + 1;
  localparam int Q_W      = CFG_W;
  localparam int QS_W     = 14;
  localparam int REM_W    = 7;

  localparam int TIMER_BITS_DEF = 20;

  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd99;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 20'd50000;
  localparam logic [CFG_W-1:0] MIN_PERIOD_RST = 20'd100000;
  localparam logic [CFG_W-1:0] SPAN_RST       = 20'd900000;

  // span / 99 and span % 99 for the reset value of the span register
  localparam logic [QS_W-1:0]  SPAN_Q_RST = QS_W'(SPAN_RST / 99);
  localparam logic [REM_W-1:0] SPAN_R_RST = REM_W'(SPAN_RST % 99);

  // Reciprocal for an exact floor(x / 99) over any 20-bit x
  localparam int          DIV99_SH = 27;
  localparam int unsigned DIV99_M  = ((32'd1 << DIV99_SH) + 32'd98) / 32'd99;
  localparam int          DIV99_MW = 21;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_MIN_PERIOD = 2'd1,
    REG_SPAN       = 2'd2
  } reg_idx_t;

  // Counter move applied by one sample, at most one step either way
  typedef struct packed {
    logic en;
    logic up;
    logic dn;
  } pstep_t;

endpackage

/* rtl/core/debounced_updown_counter_blinker.sv */
// Channel   Dir  Handshake                    Payload
// in_       in   in_tvalid / in_tready        in_tdata: button_a, button_b, elapsed_us
// out_      out  out_tvalid / out_tready      out_tdata: count_value, led_on
// cfg_      in   cfg_psel, cfg_penable        cfg_paddr, cfg_pwdata, cfg_prdata (APB)
//
// One sample per cycle while not busy and the output is not stalled: a sample is held in
// the input register, then the debouncers, counter, period and LED update in one pass into
// the output register, which raises result valid.
// A write to period_span_us rebuilds the period tracker: in_tready stays low while
// span/99 is formed and walked up to the count.
// Synchronous active-low reset; a stalled output holds its result and backs up the input.
`include "debounced_updown_counter_blinker_macros.svh"

module debounced_updown_counter_blinker #(
  parameter int TIMER_BITS = ducb_pkg::TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [0] button_a, [1] button_b, [17:2] elapsed_us
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] count_value, [7] led_on
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ducb_pkg::*;

  localparam int TW1 = TIMER_BITS + 1;
  localparam int CMPW = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  logic [CFG_W-1:0]      debounce_r, min_period_r, span_r;
  logic                  in_v_r;
  logic                  a_r, b_r;
  logic [DT_W-1:0]       dt_r;
  logic                  out_v_r;
  logic [CNT_W-1:0]      counter_r, counter_nxt, count_a;
  logic                  led_r, led_nxt;
  logic [TIMER_BITS-1:0] ft_r, ft_nxt;
  logic [TW1-1:0]        ft_sum;
  logic [TIMER_BITS-1:0] ft_adv;

  logic                  wr_en, span_wr, busy, adv, in_acc;
  logic                  rise_a, rise_b;
  reg_idx_t              wr_idx;
  pstep_t                step;
  logic [PERIOD_W-1:0]   period;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign wr_idx     = reg_idx_t'(cfg_paddr[3:2]);
  assign span_wr    = wr_en && (wr_idx == REG_SPAN);

  always_comb begin
    unique case (wr_idx)
      REG_DEBOUNCE:   cfg_prdata = 32'(debounce_r);
      REG_MIN_PERIOD: cfg_prdata = 32'(min_period_r);
      REG_SPAN:       cfg_prdata = 32'(span_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      min_period_r <= MIN_PERIOD_RST;
      span_r       <= SPAN_RST;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_DEBOUNCE:   debounce_r   <= cfg_pwdata[CFG_W-1:0];
        REG_MIN_PERIOD: min_period_r <= cfg_pwdata[CFG_W-1:0];
        REG_SPAN:       span_r       <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: input register, then result register
  assign adv       = in_v_r && !busy && (!out_v_r || out_tready);
  assign in_tready = !busy && (!in_v_r || adv);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r  <= in_tdata[0];
      b_r  <= in_tdata[1];
      dt_r <= in_tdata[17:2];
    end
  end

  ducb_debounce #(.TIMER_BITS(TIMER_BITS)) u_dbc_a (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .level       (a_r),
    .dt          (dt_r),
    .debounce_us (debounce_r),
    .rise        (rise_a)
  );

  ducb_debounce #(.TIMER_BITS(TIMER_BITS)) u_dbc_b (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .level       (b_r),
    .dt          (dt_r),
    .debounce_us (debounce_r),
    .rise        (rise_b)
  );

  // Button A first, then button B, both saturating
  always_comb begin
    count_a     = (rise_a && (counter_r < COUNT_MAX)) ? counter_r + 1'b1 : counter_r;
    counter_nxt = (rise_b && (count_a != '0)) ? count_a - 1'b1 : count_a;
  end

  assign step.en = adv;
  assign step.up = counter_nxt > counter_r;
  assign step.dn = counter_nxt < counter_r;

  ducb_period u_period (
    .clk        (clk),
    .rst_n      (rst_n),
    .span       (span_r),
    .span_wr    (span_wr),
    .min_period (min_period_r),
    .count      (counter_r),
    .step       (step),
    .period     (period),
    .busy       (busy)
  );

  assign ft_sum = {1'b0, ft_r} + TW1'(dt_r);
  assign ft_adv = ft_sum[TIMER_BITS] ? TMAX : ft_sum[TIMER_BITS-1:0];

  always_comb begin
    led_nxt = led_r;
    ft_nxt  = ft_adv;
    if (CMPW'(ft_adv) >= CMPW'(period)) begin
      led_nxt = !led_r;
      ft_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
      led_r     <= 1'b0;
      ft_r      <= '0;
    end else if (adv) begin
      counter_r <= counter_nxt;
      led_r     <= led_nxt;
      ft_r      <= ft_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {led_r, counter_r};

  `DUCB_ASSERT_ALWAYS(a_count_range, counter_r <= COUNT_MAX, "counter above maximum")
  `DUCB_ASSERT_SAME(a_busy_blocks, busy, !in_tready && !adv, "sample taken during rebuild")
  `DUCB_ASSERT_NEXT(a_count_hold, !adv || (!rise_a && !rise_b), $stable(counter_r), "bad step")

endmodule

/* rtl/core/ducb_debounce.sv */
module ducb_debounce #(
  parameter int TIMER_BITS = ducb_pkg::TIMER_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       level,
  input  logic [ducb_pkg::DT_W-1:0]  dt,
  input  logic [ducb_pkg::CFG_W-1:0] debounce_us,
  output logic                       rise
);
  import ducb_pkg::*;

  localparam int TW1 = TIMER_BITS + 1;
  localparam int DBW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  logic                  prev_r, prev_nxt;
  logic                  lock_r, lock_nxt;
  logic [TIMER_BITS-1:0] tmr_r, tmr_nxt;
  logic [TW1-1:0]        tmr_sum;
  logic [TIMER_BITS-1:0] tmr_adv;
  logic                  change;

  assign tmr_sum = {1'b0, tmr_r} + TW1'(dt);
  assign tmr_adv = tmr_sum[TIMER_BITS] ? TMAX : tmr_sum[TIMER_BITS-1:0];
  assign change  = !lock_r && (level != prev_r);
  assign rise    = en && change && level;

  always_comb begin
    prev_nxt = prev_r;
    lock_nxt = lock_r;
    tmr_nxt  = tmr_adv;
    if (change) begin
      // record new level, restart timer, enter lockout
      prev_nxt = level;
      lock_nxt = 1'b1;
      tmr_nxt  = '0;
    end else if (lock_r && (DBW'(tmr_adv) >= DBW'(debounce_us))) begin
      lock_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      lock_r <= 1'b0;
      tmr_r  <= '0;
    end else if (en) begin
      prev_r <= prev_nxt;
      lock_r <= lock_nxt;
      tmr_r  <= tmr_nxt;
    end
  end

endmodule

/* rtl/core/ducb_period.sv */
`include "debounced_updown_counter_blinker_macros.svh"

module ducb_period (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ducb_pkg::CFG_W-1:0]    span,
  input  logic                          span_wr,
  input  logic [ducb_pkg::CFG_W-1:0]    min_period,
  input  logic [ducb_pkg::CNT_W-1:0]    count,
  input  ducb_pkg::pstep_t              step,
  output logic [ducb_pkg::PERIOD_W-1:0] period,
  output logic                          busy
);
  import ducb_pkg::*;

  // Tracks q = floor(span*count/99) and r = span*count % 99 incrementally.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_WALK
  } state_t;

  localparam int PW = CFG_W + DIV99_MW;

  state_t             state_r;
  logic [QS_W-1:0]    qs_r;
  logic [REM_W-1:0]   rs_r;
  logic [Q_W-1:0]     q_r;
  logic [REM_W-1:0]   r_r;
  logic [CNT_W-1:0]   wcnt_r;

  logic [REM_W:0]     up_sum, dn_diff;
  logic               up_c, dn_b;
  logic [REM_W-1:0]   up_r, dn_r;
  logic [Q_W-1:0]     up_q, dn_q, q_sel;
  logic [PW-1:0]      div_prod;
  logic [QS_W-1:0]    div_q;
  logic [QS_W+REM_W-1:0] qs_x99;
  logic [REM_W-1:0]   rem;

  assign up_sum = {1'b0, r_r} + {1'b0, rs_r};
  assign up_c   = up_sum >= (REM_W+1)'(COUNT_MAX);
  assign up_r   = up_c ? REM_W'(up_sum - (REM_W+1)'(COUNT_MAX)) : up_sum[REM_W-1:0];
  assign up_q   = q_r + Q_W'(qs_r) + Q_W'(up_c);

  assign dn_b    = r_r < rs_r;
  assign dn_diff = dn_b ? ({1'b0, r_r} + (REM_W+1)'(COUNT_MAX) - {1'b0, rs_r})
                        : ({1'b0, r_r} - {1'b0, rs_r});
  assign dn_r    = dn_diff[REM_W-1:0];
  assign dn_q    = q_r - Q_W'(qs_r) - Q_W'(dn_b);

  assign div_prod = PW'(span) * PW'(DIV99_M);
  assign div_q    = div_prod[DIV99_SH +: QS_W];
  assign qs_x99   = (QS_W+REM_W)'(qs_r) * (QS_W+REM_W)'(COUNT_MAX);
  assign rem      = REM_W'(span - CFG_W'(qs_x99));

  always_comb begin
    q_sel = q_r;
    if (step.en && step.up) begin
      q_sel = up_q;
    end else if (step.en && step.dn) begin
      q_sel = dn_q;
    end
  end

  assign period = {1'b0, min_period} + {1'b0, q_sel};
  assign busy   = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      qs_r    <= SPAN_Q_RST;
      rs_r    <= SPAN_R_RST;
      q_r     <= '0;
      r_r     <= '0;
      wcnt_r  <= '0;
    end else if (span_wr) begin
      // a new span restarts the rebuild from any state
      state_r <= ST_DIV;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (step.en && step.up) begin
            q_r <= up_q;
            r_r <= up_r;
          end else if (step.en && step.dn) begin
            q_r <= dn_q;
            r_r <= dn_r;
          end
        end
        ST_DIV: begin
          qs_r    <= div_q;
          state_r <= ST_REM;
        end
        ST_REM: begin
          rs_r    <= rem;
          q_r     <= '0;
          r_r     <= '0;
          wcnt_r  <= '0;
          state_r <= ST_WALK;
        end
        ST_WALK: begin
          // advance one count per cycle until caught up with the counter
          if (wcnt_r == count) begin
            state_r <= ST_IDLE;
          end else begin
            q_r    <= up_q;
            r_r    <= up_r;
            wcnt_r <= wcnt_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `DUCB_ASSERT_ALWAYS(a_rem_range, (r_r < COUNT_MAX) && (rs_r < COUNT_MAX), "remainder range")
  `DUCB_ASSERT_SAME(a_no_step_busy, step.en, !busy, "counter step during period rebuild")
  `DUCB_ASSERT_NEXT(a_wr_starts, span_wr, state_r == ST_DIV, "span write did not rebuild")

endmodule
